FILE: rtl/psosb_pkg.sv
package psosb_pkg;

   // Default sizes
   localparam int THREADS_DEF      = 4;
   localparam int CELLS_DEF        = 16;
   localparam int BUFFER_DEPTH_DEF = 4;

   // Command codes
   localparam logic [1:0] CMD_READ  = 2'd0;
   localparam logic [1:0] CMD_WRITE = 2'd1;
   localparam logic [1:0] CMD_FENCE = 2'd2;
   localparam logic [1:0] CMD_PROP  = 2'd3;

   // Status codes
   localparam logic [1:0] STAT_OK     = 2'd0;
   localparam logic [1:0] STAT_EMPTY  = 2'd1;
   localparam logic [1:0] STAT_FORCED = 2'd2;

   // Access mode of strong_req
   localparam logic MODE_RLX     = 1'b0;
   localparam logic MODE_SEQ_CST = 1'b1;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_META,
      ST_ENT,
      ST_POP,
      ST_DRD,
      ST_DEX,
      ST_DENT,
      ST_DWR
   } state_type;

endpackage

FILE: rtl/pso_store_buffer_memory_unit.sv
// Store-buffer memory with one FIFO buffer per thread and cell.
// Input channel req_*: one item is a read, write, fence or propagate command.
// Result channel rsp_*: exactly one item per input item, carrying the read data
// (zero unless a read) and a status (ok, propagate on empty, forced write-out).
// One item is handled at a time. A read, a relaxed write or a propagate passes
// through state META and, for a read of a filled buffer or a write-out, state
// ENT or POP before its result; the buffer head/count memory and the entry
// memory each have a registered read. A strong write or strong fence drains
// all buffers: per cell, every thread's head/count entry is read and emptied
// (states DRD, DEX), and when the cell gets a new value the newest entry of
// the longest buffer is read and written to main memory (states DENT, DWR).
// The result sits in an output register; the next item is taken in the cycle
// the waiting result is taken. When the receiver stalls, the result holds and
// no further item is accepted until the register frees.
// After reset the head/count memory is cleared, one buffer per cycle;
// req_stall stays high during that pass.
// Main memory reads as zero until a cell is first written.
module pso_store_buffer_memory_unit #(
   parameter int THREADS      = psosb_pkg::THREADS_DEF,
   parameter int CELLS        = psosb_pkg::CELLS_DEF,
   parameter int BUFFER_DEPTH = psosb_pkg::BUFFER_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_cmd,
   input  logic [1:0]  req_thread,
   input  logic [3:0]  req_cell_req,
   input  logic [63:0] req_value,
   input  logic        req_strong_req,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_read_data,
   output logic [1:0]  rsp_status
);

   localparam int NBUF = THREADS * CELLS;
   localparam int NENT = NBUF * BUFFER_DEPTH;
   localparam int TW   = THREADS > 1 ? $clog2(THREADS) : 1;
   localparam int CW   = CELLS > 1 ? $clog2(CELLS) : 1;
   localparam int BW   = NBUF > 1 ? $clog2(NBUF) : 1;
   localparam int EW   = NENT > 1 ? $clog2(NENT) : 1;
   localparam int DW   = BUFFER_DEPTH > 1 ? $clog2(BUFFER_DEPTH) : 1;
   localparam int NW   = $clog2(BUFFER_DEPTH + 1);
   localparam int MW   = DW + NW;

   // Ring index helpers, sums stay below twice the depth
   function automatic logic [DW-1:0] ring_add(logic [DW-1:0] h, logic [NW-1:0] n);
      int s;
      s = int'(h) + int'(n);
      if (s >= BUFFER_DEPTH) s = s - BUFFER_DEPTH;
      return DW'(s);
   endfunction

   function automatic logic [DW-1:0] ring_last(logic [DW-1:0] h, logic [NW-1:0] n);
      int s;
      s = int'(h) + int'(n) - 1;
      if (s >= BUFFER_DEPTH) s = s - BUFFER_DEPTH;
      return DW'(s);
   endfunction

   function automatic logic [EW-1:0] ent_addr(logic [BW-1:0] b, logic [DW-1:0] i);
      return EW'(int'(b) * BUFFER_DEPTH + int'(i));
   endfunction

   psosb_pkg::state_type state_ff, state_in;

   logic [1:0]    cmd_ff, cmd_in;
   logic [CW-1:0] cell_ff, cell_in;
   logic [BW-1:0] buf_ff, buf_in;
   logic          ok_ff, ok_in;
   logic [63:0]   value_ff, value_in;
   logic          strong_ff, strong_in;
   logic [DW-1:0] head_ff, head_in;
   logic [NW-1:0] cnt_ff, cnt_in;
   logic [1:0]    status_ff, status_in;
   logic [CW-1:0] dc_ff, dc_in;
   logic [TW-1:0] dt_ff, dt_in;
   logic [NW-1:0] best_cnt_ff, best_cnt_in;
   logic [EW-1:0] best_addr_ff, best_addr_in;
   logic [BW-1:0] clr_ff, clr_in;
   logic [CELLS-1:0] mvalid_ff, mvalid_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [63:0]   rsp_data_ff, rsp_data_in;
   logic [1:0]    rsp_status_ff, rsp_status_in;

   logic          meta_we;
   logic [BW-1:0] meta_wa, meta_ra;
   logic [MW-1:0] meta_wd, meta_q;
   logic          ent_we;
   logic [EW-1:0] ent_wa, ent_ra;
   logic [63:0]   ent_wd, ent_q;
   logic          main_we;
   logic [CW-1:0] main_wa, main_ra;
   logic [63:0]   main_wd, main_q;

   logic          acc, req_ok, fin;
   logic [BW-1:0] req_buf, drn_buf;
   logic [DW-1:0] m_head;
   logic [NW-1:0] m_cnt;
   logic [63:0]   fin_data;
   logic [1:0]    fin_status;
   logic          dex_take;

   assign req_stall = !((state_ff == psosb_pkg::ST_IDLE) && (!rsp_valid_ff || !rsp_stall));
   assign acc       = req_valid && !req_stall;
   assign req_ok    = (int'(req_thread) < THREADS) && (int'(req_cell_req) < CELLS);
   assign req_buf   = req_ok ? BW'(int'(req_thread) * CELLS + int'(req_cell_req)) : '0;
   assign drn_buf   = BW'(int'(dt_ff) * CELLS + int'(dc_ff));
   assign m_head    = meta_q[MW-1:NW];
   assign m_cnt     = meta_q[NW-1:0];
   assign dex_take  = (m_cnt != '0) && (m_cnt >= best_cnt_ff);

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = rsp_data_ff;
   assign rsp_status    = rsp_status_ff;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         psosb_pkg::ST_CLEAR: begin
            if (clr_ff == BW'(NBUF - 1)) state_in = psosb_pkg::ST_IDLE;
         end
         psosb_pkg::ST_IDLE: begin
            if (acc) state_in = psosb_pkg::ST_META;
         end
         psosb_pkg::ST_META: begin
            unique case (cmd_ff)
               psosb_pkg::CMD_READ: begin
                  if (ok_ff && m_cnt != '0) state_in = psosb_pkg::ST_ENT;
                  else state_in = psosb_pkg::ST_IDLE;
               end
               psosb_pkg::CMD_WRITE: begin
                  if (!ok_ff) state_in = psosb_pkg::ST_IDLE;
                  else if (m_cnt == NW'(BUFFER_DEPTH)) state_in = psosb_pkg::ST_POP;
                  else if (strong_ff == psosb_pkg::MODE_SEQ_CST) state_in = psosb_pkg::ST_DRD;
                  else state_in = psosb_pkg::ST_IDLE;
               end
               psosb_pkg::CMD_FENCE: begin
                  if (strong_ff == psosb_pkg::MODE_SEQ_CST) state_in = psosb_pkg::ST_DRD;
                  else state_in = psosb_pkg::ST_IDLE;
               end
               default: begin
                  if (ok_ff && m_cnt != '0) state_in = psosb_pkg::ST_POP;
                  else state_in = psosb_pkg::ST_IDLE;
               end
            endcase
         end
         psosb_pkg::ST_ENT: state_in = psosb_pkg::ST_IDLE;
         psosb_pkg::ST_POP: begin
            if (cmd_ff == psosb_pkg::CMD_WRITE && strong_ff == psosb_pkg::MODE_SEQ_CST)
               state_in = psosb_pkg::ST_DRD;
            else state_in = psosb_pkg::ST_IDLE;
         end
         psosb_pkg::ST_DRD: state_in = psosb_pkg::ST_DEX;
         psosb_pkg::ST_DEX: begin
            if (dt_ff != TW'(THREADS - 1)) state_in = psosb_pkg::ST_DRD;
            else if (dex_take || best_cnt_ff != '0) state_in = psosb_pkg::ST_DENT;
            else if (dc_ff == CW'(CELLS - 1)) state_in = psosb_pkg::ST_IDLE;
            else state_in = psosb_pkg::ST_DRD;
         end
         psosb_pkg::ST_DENT: state_in = psosb_pkg::ST_DWR;
         psosb_pkg::ST_DWR: begin
            if (dc_ff == CW'(CELLS - 1)) state_in = psosb_pkg::ST_IDLE;
            else state_in = psosb_pkg::ST_DRD;
         end
         default: state_in = psosb_pkg::ST_IDLE;
      endcase
   end

   // Memory controls and datapath registers
   always_comb begin
      cmd_in       = cmd_ff;
      cell_in      = cell_ff;
      buf_in       = buf_ff;
      ok_in        = ok_ff;
      value_in     = value_ff;
      strong_in    = strong_ff;
      head_in      = head_ff;
      cnt_in       = cnt_ff;
      status_in    = status_ff;
      dc_in        = dc_ff;
      dt_in        = dt_ff;
      best_cnt_in  = best_cnt_ff;
      best_addr_in = best_addr_ff;
      clr_in       = clr_ff;
      mvalid_in    = mvalid_ff;
      meta_we      = 1'b0;
      meta_wa      = buf_ff;
      meta_wd      = '0;
      meta_ra      = buf_ff;
      ent_we       = 1'b0;
      ent_wa       = ent_addr(buf_ff, ring_add(m_head, m_cnt));
      ent_wd       = value_ff;
      ent_ra       = ent_addr(buf_ff, m_head);
      main_we      = 1'b0;
      main_wa      = cell_ff;
      main_wd      = ent_q;
      main_ra      = cell_ff;
      fin          = 1'b0;
      fin_data     = '0;
      fin_status   = status_ff;
      unique case (state_ff)
         psosb_pkg::ST_CLEAR: begin
            meta_we = 1'b1;
            meta_wa = clr_ff;
            clr_in  = clr_ff + BW'(1);
         end
         psosb_pkg::ST_IDLE: begin
            if (acc) begin
               cmd_in    = req_cmd;
               cell_in   = req_ok ? CW'(req_cell_req) : '0;
               buf_in    = req_buf;
               ok_in     = req_ok;
               value_in  = req_value;
               strong_in = req_strong_req;
               status_in = psosb_pkg::STAT_OK;
               meta_ra   = req_buf;
               main_ra   = req_ok ? CW'(req_cell_req) : '0;
            end
            dc_in       = '0;
            dt_in       = '0;
            best_cnt_in = '0;
         end
         psosb_pkg::ST_META: begin
            head_in = m_head;
            cnt_in  = m_cnt;
            unique case (cmd_ff)
               psosb_pkg::CMD_READ: begin
                  ent_ra = ent_addr(buf_ff, ring_last(m_head, m_cnt));
                  if (!ok_ff) begin
                     fin = 1'b1;
                  end else if (m_cnt == '0) begin
                     fin      = 1'b1;
                     fin_data = mvalid_ff[cell_ff] ? main_q : '0;
                  end
               end
               psosb_pkg::CMD_WRITE: begin
                  if (!ok_ff) begin
                     fin = 1'b1;
                  end else if (m_cnt != NW'(BUFFER_DEPTH)) begin
                     ent_we  = 1'b1;
                     meta_we = 1'b1;
                     meta_wd = {m_head, m_cnt + NW'(1)};
                     if (strong_ff != psosb_pkg::MODE_SEQ_CST) fin = 1'b1;
                  end
               end
               psosb_pkg::CMD_FENCE: begin
                  if (strong_ff != psosb_pkg::MODE_SEQ_CST) fin = 1'b1;
               end
               default: begin
                  if (!ok_ff || m_cnt == '0) begin
                     fin        = 1'b1;
                     fin_status = psosb_pkg::STAT_EMPTY;
                  end
               end
            endcase
         end
         psosb_pkg::ST_ENT: begin
            fin      = 1'b1;
            fin_data = ent_q;
         end
         psosb_pkg::ST_POP: begin
            // move the oldest entry out to main memory
            main_we            = 1'b1;
            mvalid_in[cell_ff] = 1'b1;
            meta_we            = 1'b1;
            if (cmd_ff == psosb_pkg::CMD_WRITE) begin
               ent_we    = 1'b1;
               ent_wa    = ent_addr(buf_ff, head_ff);
               meta_wd   = {ring_add(head_ff, NW'(1)), cnt_ff};
               status_in = psosb_pkg::STAT_FORCED;
               if (strong_ff != psosb_pkg::MODE_SEQ_CST) begin
                  fin        = 1'b1;
                  fin_status = psosb_pkg::STAT_FORCED;
               end
            end else begin
               meta_wd = {ring_add(head_ff, NW'(1)), cnt_ff - NW'(1)};
               fin     = 1'b1;
            end
         end
         psosb_pkg::ST_DRD: begin
            meta_ra = drn_buf;
         end
         psosb_pkg::ST_DEX: begin
            // empty this buffer, keep the newest of the longest one
            meta_wa = drn_buf;
            meta_wd = {m_head, NW'(0)};
            meta_we = (m_cnt != '0);
            if (dex_take) begin
               best_cnt_in  = m_cnt;
               best_addr_in = ent_addr(drn_buf, ring_last(m_head, m_cnt));
            end
            if (dt_ff != TW'(THREADS - 1)) begin
               dt_in = dt_ff + TW'(1);
            end else if (!dex_take && best_cnt_ff == '0) begin
               dt_in = '0;
               if (dc_ff == CW'(CELLS - 1)) fin = 1'b1;
               else dc_in = dc_ff + CW'(1);
            end
         end
         psosb_pkg::ST_DENT: begin
            ent_ra = best_addr_ff;
         end
         psosb_pkg::ST_DWR: begin
            main_we          = 1'b1;
            main_wa          = dc_ff;
            mvalid_in[dc_ff] = 1'b1;
            dt_in            = '0;
            best_cnt_in      = '0;
            if (dc_ff == CW'(CELLS - 1)) fin = 1'b1;
            else dc_in = dc_ff + CW'(1);
         end
         default: begin
         end
      endcase
   end

   // Output register: load a result, drop it once taken
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_status_in = rsp_status_ff;
      if (fin) begin
         rsp_valid_in  = 1'b1;
         rsp_data_in   = fin_data;
         rsp_status_in = fin_status;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= psosb_pkg::ST_CLEAR;
         clr_ff       <= '0;
         mvalid_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         mvalid_ff    <= mvalid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff        <= cmd_in;
      cell_ff       <= cell_in;
      buf_ff        <= buf_in;
      ok_ff         <= ok_in;
      value_ff      <= value_in;
      strong_ff     <= strong_in;
      head_ff       <= head_in;
      cnt_ff        <= cnt_in;
      status_ff     <= status_in;
      dc_ff         <= dc_in;
      dt_ff         <= dt_in;
      best_cnt_ff   <= best_cnt_in;
      best_addr_ff  <= best_addr_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_status_ff <= rsp_status_in;
   end

   psosb_ram #(.WIDTH(MW), .DEPTH(NBUF)) u_meta (
      .clock   (clock),
      .wr_en   (meta_we),
      .wr_addr (meta_wa),
      .wr_data (meta_wd),
      .rd_addr (meta_ra),
      .rd_data (meta_q)
   );

   psosb_ram #(.WIDTH(64), .DEPTH(NENT)) u_entries (
      .clock   (clock),
      .wr_en   (ent_we),
      .wr_addr (ent_wa),
      .wr_data (ent_wd),
      .rd_addr (ent_ra),
      .rd_data (ent_q)
   );

   psosb_ram #(.WIDTH(64), .DEPTH(CELLS)) u_main (
      .clock   (clock),
      .wr_en   (main_we),
      .wr_addr (main_wa),
      .wr_data (main_wd),
      .rd_addr (main_ra),
      .rd_data (main_q)
   );

`ifndef ASSERT_OFF
   a_result_slot_free: assert property (@(posedge clock) disable iff (reset)
      fin |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result produced while output register busy");

   a_drain_count_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == psosb_pkg::ST_DEX) |-> (m_cnt <= NW'(BUFFER_DEPTH)))
      else $error("buffer count beyond depth during drain");

   a_main_valid_sticky: assert property (@(posedge clock) disable iff (reset)
      (mvalid_ff != '0) |=> (mvalid_ff != '0))
      else $error("main memory valid bits lost");
`endif

endmodule

FILE: rtl/psosb_ram.sv
module psosb_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write one entry, register the read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

FILE: bench/tb_pso_store_buffer_memory_unit.sv
module tb_pso_store_buffer_memory_unit;

   localparam int NTHR      = 4;
   localparam int NCELL     = 16;
   localparam int DEPTH     = 4;
   localparam int EXP_SLOTS = 1024;
   localparam int MAX_ROWS  = 64;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [1:0]  req_cmd;
   logic [1:0]  req_thread;
   logic [3:0]  req_cell_req;
   logic [63:0] req_value;
   logic        req_strong_req;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [63:0] rsp_read_data;
   logic [1:0]  rsp_status;

   pso_store_buffer_memory_unit i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_cmd        (req_cmd),
      .req_thread     (req_thread),
      .req_cell_req   (req_cell_req),
      .req_value      (req_value),
      .req_strong_req (req_strong_req),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_read_data  (rsp_read_data),
      .rsp_status     (rsp_status)
   );

   typedef struct packed {
      logic [63:0] data;
      logic [1:0]  status;
   } access_result_type;

   typedef struct {
      logic [1:0]  cmd;
      logic [1:0]  thr;
      logic [3:0]  cell_idx;
      logic [63:0] value;
      logic        strong_mode;
      logic        known;
      logic [63:0] data;
      logic [1:0]  status;
   } access_row_type;

   // mirror of the memory and the per-buffer FIFOs
   logic [63:0] mem_copy [NCELL];
   logic [63:0] fifo_data [NTHR][NCELL][DEPTH];
   int          fifo_head [NTHR][NCELL];
   int          fifo_count [NTHR][NCELL];

   // expected results in order of acceptance
   access_result_type exp_results [EXP_SLOTS];
   int                exp_wr;
   int                exp_rd;
   access_row_type    directed_rows [MAX_ROWS];
   int          row_count;
   int          error_count;
   int          items_sent;
   int          results_seen;
   int          sender_idle_pct;
   int          receiver_stall_pct;
   int          hold_cycles;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("mismatch %s: got %h expected %h (result %0d)", what, got, want,
               results_seen);
      error_count++;
   endtask

   // move the oldest entry of one buffer into memory
   function automatic void pop_into_memory(input int t, input int c);
      mem_copy[c] = fifo_data[t][c][fifo_head[t][c]];
      fifo_head[t][c] = (fifo_head[t][c] + 1) % DEPTH;
      fifo_count[t][c]--;
   endfunction

   function automatic void drain_buffers();
      bit busy;
      busy = 1'b1;
      while (busy) begin
         busy = 1'b0;
         for (int t = 0; t < NTHR; t++)
            for (int c = 0; c < NCELL; c++)
               if (fifo_count[t][c] != 0) begin
                  pop_into_memory(t, c);
                  busy = 1'b1;
               end
      end
   endfunction

   function automatic access_result_type apply_access(input logic [1:0] cmd,
         input logic [1:0] thr, input logic [3:0] cell_idx, input logic [63:0] value,
         input logic strong_mode);
      access_result_type r;
      int t;
      int c;
      r = '0;
      t = int'(thr);
      c = int'(cell_idx);
      unique case (cmd)
         psosb_pkg::CMD_READ: begin
            if (fifo_count[t][c] == 0) r.data = mem_copy[c];
            else r.data = fifo_data[t][c][(fifo_head[t][c] + fifo_count[t][c] - 1) % DEPTH];
         end
         psosb_pkg::CMD_WRITE: begin
            if (fifo_count[t][c] >= DEPTH) begin
               pop_into_memory(t, c);
               r.status = psosb_pkg::STAT_FORCED;
            end
            fifo_data[t][c][(fifo_head[t][c] + fifo_count[t][c]) % DEPTH] = value;
            fifo_count[t][c]++;
            if (strong_mode == psosb_pkg::MODE_SEQ_CST) drain_buffers();
         end
         psosb_pkg::CMD_FENCE: begin
            if (strong_mode == psosb_pkg::MODE_SEQ_CST) drain_buffers();
         end
         default: begin
            if (fifo_count[t][c] != 0) pop_into_memory(t, c);
            else r.status = psosb_pkg::STAT_EMPTY;
         end
      endcase
      return r;
   endfunction

   // offer one item and wait for acceptance; valid drops only while idling
   task automatic send_access(input logic [1:0] cmd, input logic [1:0] thr,
         input logic [3:0] cell_idx, input logic [63:0] value, input logic strong_mode,
         input logic known, input access_result_type want);
      access_result_type r;
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_cmd        <= cmd;
      req_thread     <= thr;
      req_cell_req   <= cell_idx;
      req_value      <= value;
      req_strong_req <= strong_mode;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      r = apply_access(cmd, thr, cell_idx, value, strong_mode);
      if (known && r.data != want.data)
         report_mismatch("directed row data vs predictor", r.data, want.data);
      if (known && r.status != want.status)
         report_mismatch("directed row status vs predictor", {62'd0, r.status},
                         {62'd0, want.status});
      exp_results[exp_wr % EXP_SLOTS] = r;
      exp_wr++;
      items_sent++;
   endtask

   task automatic wait_results_drained();
      int guard;
      guard = 0;
      while (exp_wr != exp_rd && guard < 200000) begin
         @(posedge clock);
         guard++;
      end
   endtask

   task automatic add_row(input logic [1:0] cmd, input logic [1:0] thr,
         input logic [3:0] cell_idx, input logic [63:0] value, input logic strong_mode,
         input logic known, input logic [63:0] data, input logic [1:0] status);
      access_row_type row;
      row.cmd = cmd; row.thr = thr; row.cell_idx = cell_idx; row.value = value;
      row.strong_mode = strong_mode; row.known = known; row.data = data;
      row.status = status;
      directed_rows[row_count] = row;
      row_count++;
   endtask

   // random item: mostly writes/reads on a few hot cells so buffers fill
   task automatic send_random();
      logic [1:0]  cmd;
      logic [3:0]  cell_idx;
      logic [63:0] value;
      int pick;
      pick = $urandom_range(99);
      if (pick < 40) cmd = psosb_pkg::CMD_WRITE;
      else if (pick < 70) cmd = psosb_pkg::CMD_READ;
      else if (pick < 88) cmd = psosb_pkg::CMD_PROP;
      else cmd = psosb_pkg::CMD_FENCE;
      cell_idx = ($urandom_range(3) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(2));
      value = {$urandom, $urandom};
      send_access(cmd, 2'($urandom_range(3)), cell_idx, value,
                  ($urandom_range(9) == 0), 1'b0, '0);
   endtask

   // check each result against the oldest expectation
   always @(posedge clock) begin
      access_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (exp_wr == exp_rd) begin
            report_mismatch("unexpected result", rsp_read_data, 64'd0);
         end else begin
            want = exp_results[exp_rd % EXP_SLOTS];
            exp_rd++;
            if (rsp_read_data !== want.data)
               report_mismatch("read_data", rsp_read_data, want.data);
            if (rsp_status !== want.status)
               report_mismatch("status", {62'd0, rsp_status}, {62'd0, want.status});
         end
         results_seen++;
      end
   end

   // receiver stall, with an optional long hold-off
   always @(posedge clock) begin
      if (hold_cycles > 0) begin
         rsp_stall <= 1'b1;
         hold_cycles <= hold_cycles - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
      end
   end

   initial begin
      #50_000_000;
      $display("tb_pso_store_buffer_memory_unit: errors");
      $finish;
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_cmd = psosb_pkg::CMD_READ;
      req_thread = '0;
      req_cell_req = '0;
      req_value = '0;
      req_strong_req = psosb_pkg::MODE_RLX;
      rsp_stall = 1'b0;
      exp_wr = 0;
      exp_rd = 0;
      row_count = 0;
      error_count = 0;
      items_sent = 0;
      results_seen = 0;
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      hold_cycles = 0;
      for (int c = 0; c < NCELL; c++) begin
         mem_copy[c] = '0;
         for (int t = 0; t < NTHR; t++) begin
            fifo_head[t][c] = 0;
            fifo_count[t][c] = 0;
            for (int k = 0; k < DEPTH; k++) fifo_data[t][c][k] = '0;
         end
      end
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed rows: after reset, extremes, overflow, empty propagate, fences
      add_row(psosb_pkg::CMD_READ,  2'd3, 4'd15, '0, psosb_pkg::MODE_RLX, 1'b1, 64'd0,
              psosb_pkg::STAT_OK);
      add_row(psosb_pkg::CMD_PROP,  2'd0, 4'd0,  '0, psosb_pkg::MODE_RLX, 1'b1, 64'd0,
              psosb_pkg::STAT_EMPTY);
      add_row(psosb_pkg::CMD_WRITE, 2'd0, 4'd0, {64{1'b1}}, psosb_pkg::MODE_RLX, 1'b1,
              64'd0, psosb_pkg::STAT_OK);
      add_row(psosb_pkg::CMD_READ,  2'd0, 4'd0,  '0, psosb_pkg::MODE_RLX, 1'b1, {64{1'b1}},
              psosb_pkg::STAT_OK);
      add_row(psosb_pkg::CMD_READ,  2'd1, 4'd0,  '0, psosb_pkg::MODE_RLX, 1'b1, 64'd0,
              psosb_pkg::STAT_OK);
      add_row(psosb_pkg::CMD_WRITE, 2'd0, 4'd0, 64'h5555_5555_5555_5555,
              psosb_pkg::MODE_RLX, 1'b0, '0, '0);
      add_row(psosb_pkg::CMD_WRITE, 2'd0, 4'd0, 64'hAAAA_AAAA_AAAA_AAAA,
              psosb_pkg::MODE_RLX, 1'b0, '0, '0);
      add_row(psosb_pkg::CMD_WRITE, 2'd0, 4'd0, 64'd1, psosb_pkg::MODE_RLX, 1'b1, 64'd0,
              psosb_pkg::STAT_OK);
      add_row(psosb_pkg::CMD_WRITE, 2'd0, 4'd0, 64'd2, psosb_pkg::MODE_RLX, 1'b1, 64'd0,
              psosb_pkg::STAT_FORCED);
      add_row(psosb_pkg::CMD_READ,  2'd1, 4'd0,  '0, psosb_pkg::MODE_RLX, 1'b1, {64{1'b1}},
              psosb_pkg::STAT_OK);
      add_row(psosb_pkg::CMD_PROP,  2'd0, 4'd0,  '0, psosb_pkg::MODE_RLX, 1'b0, '0, '0);
      add_row(psosb_pkg::CMD_WRITE, 2'd3, 4'd15, 64'h8000_0000_0000_0000,
              psosb_pkg::MODE_RLX, 1'b0, '0, '0);
      add_row(psosb_pkg::CMD_FENCE, 2'd2, 4'd7,  '0, psosb_pkg::MODE_RLX, 1'b1, 64'd0,
              psosb_pkg::STAT_OK);
      add_row(psosb_pkg::CMD_READ,  2'd0, 4'd15, '0, psosb_pkg::MODE_RLX, 1'b1, 64'd0,
              psosb_pkg::STAT_OK);
      add_row(psosb_pkg::CMD_FENCE, 2'd1, 4'd3,  '0, psosb_pkg::MODE_SEQ_CST, 1'b1, 64'd0,
              psosb_pkg::STAT_OK);
      add_row(psosb_pkg::CMD_READ,  2'd2, 4'd15, '0, psosb_pkg::MODE_RLX, 1'b0, '0, '0);
      add_row(psosb_pkg::CMD_READ,  2'd2, 4'd0,  '0, psosb_pkg::MODE_RLX, 1'b0, '0, '0);
      add_row(psosb_pkg::CMD_WRITE, 2'd2, 4'd9, 64'h0123_4567_89AB_CDEF,
              psosb_pkg::MODE_SEQ_CST, 1'b1, 64'd0, psosb_pkg::STAT_OK);
      add_row(psosb_pkg::CMD_READ,  2'd1, 4'd9,  '0, psosb_pkg::MODE_RLX, 1'b1,
              64'h0123_4567_89AB_CDEF, psosb_pkg::STAT_OK);
      add_row(psosb_pkg::CMD_PROP,  2'd2, 4'd9,  '0, psosb_pkg::MODE_SEQ_CST, 1'b1, 64'd0,
              psosb_pkg::STAT_EMPTY);

      // walk the table
      for (int i = 0; i < row_count; i++)
         send_access(directed_rows[i].cmd, directed_rows[i].thr, directed_rows[i].cell_idx,
                     directed_rows[i].value, directed_rows[i].strong_mode,
                     directed_rows[i].known,
                     '{data: directed_rows[i].data, status: directed_rows[i].status});

      // sender pauses until every result is back
      req_valid <= 1'b0;
      wait_results_drained();

      // random phases: none, sender idle, receiver stall, both
      for (int ph = 0; ph < 4; ph++) begin
         sender_idle_pct    = (ph == 1 || ph == 3) ? ((ph == 3) ? 9 : 54) : 0;
         receiver_stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 9 : 54) : 0;
         if (ph == 2) hold_cycles = 300;
         for (int n = 0; n < 95; n++) send_random();
      end
      req_valid <= 1'b0;
      sender_idle_pct = 0;
      receiver_stall_pct = 0;

      wait_results_drained();
      repeat (200) @(posedge clock);
      if (exp_wr != exp_rd) begin
         $display("%0d results never arrived", exp_wr - exp_rd);
         error_count++;
      end
      $display("sent %0d items (directed table plus random reads/writes/fences/propagates),",
               items_sent);
      $display("checked %0d results under four idle/stall mixes and a long hold-off",
               results_seen);
      if (error_count == 0) $display("tb_pso_store_buffer_memory_unit: clean");
      else $display("tb_pso_store_buffer_memory_unit: errors");
      $finish;
   end

endmodule
